### hw/rtl/cpbf_pkg.sv
package cpbf_pkg;

   typedef struct packed {
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               overflowed;
      logic [33:0]        dist_squared;
      logic [16:0]        distance;
      logic [7:0]         index_first;
      logic [7:0]         index_second;
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_z;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_z;
   } rsp_type;

   localparam int unsigned CoordW = 16;
   localparam int unsigned DistW  = 34;
   localparam int unsigned RootW  = 17;

   // One stored point, all three axes as loaded.
   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } point_type;

   // Running best pair, updated from the end of the chain of compare cells.
   typedef struct packed {
      logic             have;
      logic [DistW-1:0] best;
      logic [11:0]      bi;
      logic [11:0]      bj;
   } best_type;

endpackage

### hw/rtl/closest_pair_brute_force_unit.sv
// Closest pair of points, brute force.
// req_ channel: one point per beat; last_point closes the set and starts
// the search. rsp_ channel: one result beat per set, carrying the winning
// pair, its squared distance and floor square root. csr_ channel: one beat
// writes the dimensions register (1..3 axes, 0 acts as 1); user writes only while
// idle, unenforced. Loading accepts one point per cycle in the load state. The search
// reads the point memory once per pair through a single read port and
// pushes the pair down a chain of three axis cells. For N points it steps
// through N*(N-1)/2 pairs, fetching point i before each row, then drains
// the chain and runs the square root, whose result is registered in the
// output register. Points beyond MAX_POINTS are dropped and flagged.
// Reset clears the point count, flags and state; the memory needs no clear.
// The result waits in an output register while rsp_ready is low. Loading of
// the next set goes on meanwhile; its search holds before the square root
// until that register has been taken.
module closest_pair_brute_force_unit #(
   parameter int unsigned MAX_POINTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cpbf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpbf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);
   import cpbf_pkg::*;

   localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned CW = AW + 1;
   localparam int unsigned Lat = 5;

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_FETCH = 6'b000010,
      ST_PAIR  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_ROOT  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   point_type   mem [MAX_POINTS];
   logic [CW-1:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic [1:0]  dims_ff, axes_ff, axes_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;
   point_type   pi_ff, rd_ff;
   logic [AW-1:0] rd_addr;
   logic        pv_ff;
   point_type   pa_ff, pb_ff;
   logic [DistW-1:0] s0, s1, s2;
   best_type    best_ff, best_in;
   logic        root_start, root_done;
   logic [RootW-1:0] root;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  drain_ff, drain_in;
   logic        take;
   point_type   fa_ff, fb_ff;
   logic        issue;
   logic [4:0]  rstep_ff;

   assign req_ready = state_ff == ST_LOAD;
   assign csr_ready = 1'b1;
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      axes_in   = axes_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      drain_in  = drain_ff;
      root_start = 1'b0;
      issue     = 1'b0;
      rd_addr   = j_ff;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_LOAD: begin
            if (take) begin
               if (count_ff < CW'(MAX_POINTS)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_point) begin
                  axes_in  = (dims_ff == 2'd0) ? 2'd1 : dims_ff;
                  i_in     = '0;
                  j_in     = AW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            rd_addr = i_ff;
            if (count_ff < CW'(2) || {1'b0, i_ff} >= count_ff - CW'(1)) begin
               drain_in = 3'(Lat);
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            issue = 1'b1;
            if ({1'b0, j_ff} == count_ff - CW'(1)) begin
               i_in     = i_ff + AW'(1);
               j_in     = i_ff + AW'(2);
               state_in = ST_FETCH;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            // hold until the previous result has left the output register
            if (drain_ff != 3'd0) begin
               drain_in = drain_ff - 3'd1;
            end else if (!rsp_valid_ff) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rd_addr = (rstep_ff == 5'd1) ? AW'(best_ff.bi) : AW'(best_ff.bj);
            if (root_done) begin
               rsp_in = '0;
               rsp_in.overflowed = ovf_ff;
               if (best_ff.have) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.dist_squared = best_ff.best;
                  rsp_in.distance     = root;
                  rsp_in.index_first  = 8'(best_ff.bi);
                  rsp_in.index_second = 8'(best_ff.bj);
                  rsp_in.first_x  = fa_ff.x;
                  rsp_in.first_y  = fa_ff.y;
                  rsp_in.first_z  = fa_ff.z;
                  rsp_in.second_x = fb_ff.x;
                  rsp_in.second_y = fb_ff.y;
                  rsp_in.second_z = fb_ff.z;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Point memory: one write port for loading, one read port for the search.
   always_ff @(posedge clock) begin
      if (take && count_ff < CW'(MAX_POINTS)) begin
         mem[count_ff[AW-1:0]] <= '{x: req_data.coord_x, y: req_data.coord_y,
                                    z: req_data.coord_z};
      end
      rd_ff <= mem[rd_addr];
   end

   // Hold point i while j sweeps; the read of i lands in rd_ff in the cycle after FETCH.
   logic fetch_d_ff;
   always_ff @(posedge clock) begin
      fetch_d_ff <= state_ff == ST_FETCH;
      if (fetch_d_ff) begin
         pi_ff <= rd_ff;
      end
   end

   // Issue stage: pair address travels with the read; its valid is registered alongside.
   logic [AW-1:0] ji_ff, ii_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= issue;
      end
      ji_ff <= j_ff;
      ii_ff <= i_ff;
      pa_ff <= fetch_d_ff ? rd_ff : pi_ff;
      pb_ff <= rd_ff;
   end

   // pa_ff must reflect point i for the first pair too; the i read returns
   // during the first PAIR cycle and the j read after it, so both line up here.
   logic pv2_ff;
   logic [AW-1:0] i2_ff, j2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pv2_ff <= 1'b0;
      end else begin
         pv2_ff <= pv_ff;
      end
      i2_ff <= ii_ff;
      j2_ff <= ji_ff;
   end

   // Chain of axis cells, each adding one squared difference when its axis is in use.
   point_type a1_ff, b1_ff, a2_ff, b2_ff;
   always_ff @(posedge clock) begin
      a1_ff <= pa_ff;
      b1_ff <= pb_ff;
      a2_ff <= a1_ff;
      b2_ff <= b1_ff;
   end

   cpbf_cell u_cell_x (.clock(clock), .enable(1'b1), .a(pa_ff.x), .b(pb_ff.x),
      .use_axis(1'b1), .sum_in('0), .sum_out(s0));
   cpbf_cell u_cell_y (.clock(clock), .enable(1'b1), .a(a1_ff.y), .b(b1_ff.y),
      .use_axis(axes_ff >= 2'd2), .sum_in(s0), .sum_out(s1));
   cpbf_cell u_cell_z (.clock(clock), .enable(1'b1), .a(a2_ff.z), .b(b2_ff.z),
      .use_axis(axes_ff == 2'd3), .sum_in(s1), .sum_out(s2));

   logic [2:0] cv_ff;
   logic [AW-1:0] ci_ff [3];
   logic [AW-1:0] cj_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else begin
         cv_ff <= {cv_ff[1:0], pv2_ff};
      end
      ci_ff[0] <= i2_ff;
      cj_ff[0] <= j2_ff;
      ci_ff[1] <= ci_ff[0];
      cj_ff[1] <= cj_ff[0];
      ci_ff[2] <= ci_ff[1];
      cj_ff[2] <= cj_ff[1];
   end

   always_comb begin
      best_in = best_ff;
      if (state_ff == ST_LOAD) begin
         best_in.have = 1'b0;
      end else if (cv_ff[2] && (!best_ff.have || s2 < best_ff.best)) begin
         best_in.have = 1'b1;
         best_in.best = s2;
         best_in.bi   = 12'(ci_ff[2]);
         best_in.bj   = 12'(cj_ff[2]);
      end
   end

   cpbf_sqrt u_sqrt (.clock(clock), .reset(reset), .start(root_start),
      .radicand(best_ff.best), .done(root_done), .root(root));

   // Fetch the winning coordinates while the root iterates.
   always_ff @(posedge clock) begin
      if (root_start) begin
         rstep_ff <= '0;
      end else if (rstep_ff != 5'd31) begin
         rstep_ff <= rstep_ff + 5'd1;
      end
      if (state_ff == ST_ROOT && rstep_ff == 5'd2) begin
         fa_ff <= rd_ff;
      end
      if (state_ff == ST_ROOT && rstep_ff == 5'd3) begin
         fb_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         dims_ff      <= 2'd3;
         rsp_valid_ff <= 1'b0;
         best_ff.have <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         best_ff.have <= best_in.have;
         if (csr_valid && csr_ready) begin
            dims_ff <= csr_data;
         end
      end
      axes_ff      <= axes_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      drain_ff     <= drain_in;
      rsp_ff       <= rsp_in;
      best_ff.best <= best_in.best;
      best_ff.bi   <= best_in.bi;
      best_ff.bj   <= best_in.bj;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

### hw/rtl/cpbf_cell.sv
// One compare cell: squares one axis difference and, when use_axis is set,
// accumulates it into the partial distance passed from its neighbour.
module cpbf_cell (
   input  logic                             clock,
   input  logic                             enable,
   input  logic signed [cpbf_pkg::CoordW-1:0] a,
   input  logic signed [cpbf_pkg::CoordW-1:0] b,
   input  logic                             use_axis,
   input  logic [cpbf_pkg::DistW-1:0]       sum_in,
   output logic [cpbf_pkg::DistW-1:0]       sum_out
);
   import cpbf_pkg::*;

   logic signed [CoordW:0] diff;
   logic [CoordW:0]        mag;
   logic [DistW-1:0]       sq;
   logic [DistW-1:0]       sum_ff;
   logic [DistW-1:0]       sum_in_w;

   always_comb begin
      diff = {a[CoordW-1], a} - {b[CoordW-1], b};
      mag  = diff[CoordW] ? CoordW'(1) + (CoordW+1)'(~diff) : (CoordW+1)'(diff);
      sq   = DistW'(mag) * DistW'(mag);
      sum_in_w = use_axis ? sum_in + sq : sum_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in_w;
      end
   end

   assign sum_out = sum_ff;
endmodule

### hw/rtl/cpbf_sqrt.sv
// Bit-pair restoring square root, one result bit per cycle.
module cpbf_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cpbf_pkg::DistW-1:0]  radicand,
   output logic                        done,
   output logic [cpbf_pkg::RootW-1:0]  root
);
   import cpbf_pkg::*;

   localparam int unsigned RemW = RootW + 2;

   logic [DistW-1:0] n_ff, n_in;
   logic [RemW-1:0]  rem_ff, rem_in;
   logic [RootW-1:0] res_ff, res_in;
   logic [4:0]       step_ff, step_in;
   logic             busy_ff, busy_in;
   logic [RemW-1:0]  trial;

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         n_in    = radicand;
         rem_in  = '0;
         res_in  = '0;
         step_in = 5'(RootW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = {rem_ff[RemW-3:0], n_ff[DistW-1 -: 2]};
         n_in   = {n_ff[DistW-3:0], 2'b00};
         trial  = {res_ff, 2'b01};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            res_in = {res_ff[RootW-2:0], 1'b1};
         end else begin
            res_in = {res_ff[RootW-2:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         busy_in = step_ff != 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      step_ff <= step_in;
   end

   assign done = busy_ff && step_ff == 5'd1;
   assign root = res_in;
endmodule

### tb/sv/closest_pair_checker.sv
`timescale 1ns / 100ps

module closest_pair_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cpbf_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cpbf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_data,
   output int                fail_count,
   output int                pending_results
);
   import cpbf_pkg::*;

   localparam int Capacity = 256;

   point_type points [Capacity];
   int        loaded;
   logic      dropped;
   logic [1:0] axes_reg;
   rsp_type   pair_queue [$];

   function automatic logic [16:0] floor_root(input logic [33:0] n);
      logic [16:0] r;
      r = '0;
      for (int b = 16; b >= 0; b--) begin
         logic [16:0] t;
         t = r | (17'd1 << b);
         if ({17'd0, t} * {17'd0, t} <= {17'd0, n}) r = t;
      end
      return r;
   endfunction

   function automatic logic [33:0] span_sq(input point_type a, input point_type b,
                                           input int n);
      logic [33:0] s;
      longint d;
      s = '0;
      d = longint'(a.x) - longint'(b.x); s += 34'(d * d);
      if (n > 1) begin d = longint'(a.y) - longint'(b.y); s += 34'(d * d); end
      if (n > 2) begin d = longint'(a.z) - longint'(b.z); s += 34'(d * d); end
      return s;
   endfunction

   function automatic rsp_type search_set(input int n_axes);
      rsp_type r;
      logic have;
      logic [33:0] best, d;
      int bi, bj;
      r = '0; have = 1'b0; best = '0; bi = 0; bj = 0;
      for (int i = 0; i < loaded; i++)
         for (int j = i + 1; j < loaded; j++) begin
            d = span_sq(points[i], points[j], n_axes);
            if (!have || d < best) begin
               have = 1'b1; best = d; bi = i; bj = j;
            end
         end
      r.overflowed = dropped;
      if (have) begin
         r.found = 1'b1; r.dist_squared = best; r.distance = floor_root(best);
         r.index_first = 8'(bi); r.index_second = 8'(bj);
         r.first_x = points[bi].x; r.first_y = points[bi].y; r.first_z = points[bi].z;
         r.second_x = points[bj].x; r.second_y = points[bj].y; r.second_z = points[bj].z;
      end
      return r;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         loaded = 0; dropped = 1'b0; axes_reg = 2'd3; fail_count = 0;
         pair_queue.delete();
      end else begin
         if (csr_valid && csr_ready) axes_reg = csr_data;
         if (req_valid && req_ready) begin
            if (loaded < Capacity) begin
               points[loaded] = '{x: req_data.coord_x, y: req_data.coord_y,
                                  z: req_data.coord_z};
               loaded++;
            end else dropped = 1'b1;
            if (req_data.last_point) begin
               pair_queue.push_back(search_set(axes_reg == 0 ? 1 : int'(axes_reg)));
               loaded = 0; dropped = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pair_queue.size() == 0)
               report("unexpected beat", 64'(rsp_data.dist_squared), 64'(0));
            else begin
               want = pair_queue.pop_front();
               if (rsp_data.found != want.found)
                  report("found", 64'(rsp_data.found), 64'(want.found));
               if (rsp_data.overflowed != want.overflowed)
                  report("overflowed", 64'(rsp_data.overflowed), 64'(want.overflowed));
               if (rsp_data.dist_squared != want.dist_squared)
                  report("dist_squared", 64'(rsp_data.dist_squared),
                         64'(want.dist_squared));
               if (rsp_data.distance != want.distance)
                  report("distance", 64'(rsp_data.distance), 64'(want.distance));
               if (rsp_data.index_first != want.index_first)
                  report("index_first", 64'(rsp_data.index_first), 64'(want.index_first));
               if (rsp_data.index_second != want.index_second)
                  report("index_second", 64'(rsp_data.index_second),
                         64'(want.index_second));
               if (rsp_data.first_x != want.first_x)
                  report("first_x", 64'(rsp_data.first_x), 64'(want.first_x));
               if (rsp_data.first_y != want.first_y)
                  report("first_y", 64'(rsp_data.first_y), 64'(want.first_y));
               if (rsp_data.first_z != want.first_z)
                  report("first_z", 64'(rsp_data.first_z), 64'(want.first_z));
               if (rsp_data.second_x != want.second_x)
                  report("second_x", 64'(rsp_data.second_x), 64'(want.second_x));
               if (rsp_data.second_y != want.second_y)
                  report("second_y", 64'(rsp_data.second_y), 64'(want.second_y));
               if (rsp_data.second_z != want.second_z)
                  report("second_z", 64'(rsp_data.second_z), 64'(want.second_z));
            end
         end
      end
      pending_results = pair_queue.size();
   end

endmodule

### tb/sv/closest_pair_brute_force_unit_test.sv
`timescale 1ns / 100ps

module closest_pair_brute_force_unit_test;
   import cpbf_pkg::*;

   localparam int StallLimit = 200000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   req_type req_data = '0;
   logic rsp_valid, rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_data = 2'd3;
   int fail_count, pending_results;
   logic steady = 0;
   int idle_cycles = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   closest_pair_brute_force_unit DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_data
   );

   closest_pair_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_data, .fail_count, .pending_results
   );

   // receiver: stall in bursts, never in the closing stretch
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 9);
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // valid stays high into the next beat; drop it only before an idle stretch
   task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic last);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_data <= '{coord_x: x, coord_y: y, coord_z: z, last_point: last};
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_results != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic set_axes(input logic [1:0] v);
      drain();
      csr_data <= v;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [15:0] any_coord(input int range_sel);
      case (range_sel)
         0: return 16'($urandom_range(0, 15) - 8);
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_set(input int n, input int range_sel);
      for (int i = 0; i < n; i++)
         send_point(any_coord(range_sel), any_coord(range_sel), any_coord(range_sel),
                    i == n - 1);
   endtask

   initial begin
      int sent, n;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // extremes: opposite corners give the largest squared distance
      send_point(16'h8000, 16'h8000, 16'h8000, 0);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 1);
      // a lone point, and a tie where the earliest pair must stay
      send_point(16'h0005, 16'h0000, 16'h0000, 1);
      send_point(0, 0, 0, 0);
      send_point(16'h0003, 0, 0, 0);
      send_point(16'h0006, 0, 0, 0);
      send_point(16'hfffd, 16'hffff, 16'h1234, 1);
      set_axes(2'd0);
      send_point(16'h0001, 16'h7fff, 16'h8000, 0);
      send_point(16'h0002, 16'h8000, 16'h7fff, 1);
      set_axes(2'd2);
      send_point(16'h0001, 16'h0100, 16'h8000, 0);
      send_point(16'h0003, 16'h0100, 16'h7fff, 0);
      send_point(16'h0100, 16'h0101, 16'h0000, 1);
      set_axes(2'd1);
      random_set(4, 0);
      // full store plus dropped points, last one dropped too
      set_axes(2'd3);
      random_set(259, 2);
      sent = 275;

      while (sent < 700) begin
         if ($urandom_range(0, 7) == 0) set_axes(2'($urandom_range(0, 3)));
         if ($urandom_range(0, 9) == 0) drain();
         if (sent > 620) steady = 1;
         n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(2, 12);
         random_set(n, $urandom_range(0, 2));
         sent += n;
      end
      steady = 1;
      drain();
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
